// File: hdl/cnb_pkg.sv
// Shared constants for the categorical naive Bayes classifier.
package cnb_pkg;

    localparam int DEF_NUM_CLASSES = 4;
    localparam int DEF_ATTR_VALUES = 16;
    localparam int DEF_COUNT_BITS  = 16;
    localparam int DEF_MAX_ATTRS   = 4;

    localparam int ATTR_PORTS  = 4;
    localparam int ATTR_W      = 4;
    localparam int LABEL_W     = 2;
    localparam int CFG_W       = 3;
    localparam int OUT_CLASS_W = 2;

    localparam logic [CFG_W-1:0] ATTRS_RESET = 3'd2;

    localparam logic ACT_TRAIN   = 1'b0;
    localparam logic ACT_PREDICT = 1'b1;

endpackage

// File: hdl/cnb_count_ram.sv
// Value-per-class count memory: one write port, one registered read port.
module cnb_count_ram #(
    parameter int DEPTH  = cnb_pkg::DEF_NUM_CLASSES * cnb_pkg::DEF_ATTR_VALUES,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = cnb_pkg::DEF_COUNT_BITS
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/cnb_limb_mac.sv
// One limb step of a wide multiply: a * f + carry, split into low limb and carry out.
module cnb_limb_mac #(
    parameter int LIMB_W = cnb_pkg::DEF_COUNT_BITS
) (
    input  logic [LIMB_W-1:0] limb_in,
    input  logic [LIMB_W-1:0] factor,
    input  logic [LIMB_W-1:0] carry_in,
    output logic [LIMB_W-1:0] limb_out,
    output logic [LIMB_W-1:0] carry_out
);

    logic [2*LIMB_W-1:0] prod;

    assign prod      = (2*LIMB_W)'(limb_in) * (2*LIMB_W)'(factor) + (2*LIMB_W)'(carry_in);
    assign limb_out  = prod[LIMB_W-1:0];
    assign carry_out = prod[2*LIMB_W-1:LIMB_W];

endmodule

// File: hdl/categorical_naive_bayes.sv
// Categorical naive Bayes top level: counters, sequencer and limb-serial scoring.
// One item at a time. Train: a class-count update, then a read and a write per attribute
// (k = attributes in use). Predict: L = 2*MAX_ATTRS-1 limbs per product on one limb multiplier;
// unseen classes are skipped, seen classes are scored limb by limb, and once one scores nonzero
// each later one also rescores the best class and compares limb by limb; the result item waits
// on a held result. Reset: synchronous active low, then the count memory clears, s_ready low.
module categorical_naive_bayes #(
    parameter int NUM_CLASSES = cnb_pkg::DEF_NUM_CLASSES,
    parameter int ATTR_VALUES = cnb_pkg::DEF_ATTR_VALUES,
    parameter int COUNT_BITS  = cnb_pkg::DEF_COUNT_BITS,
    parameter int MAX_ATTRS   = cnb_pkg::DEF_MAX_ATTRS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [cnb_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [cnb_pkg::LABEL_W-1:0]       s_class_label,
    input  logic [cnb_pkg::ATTR_W-1:0]        s_attr_0,
    input  logic [cnb_pkg::ATTR_W-1:0]        s_attr_1,
    input  logic [cnb_pkg::ATTR_W-1:0]        s_attr_2,
    input  logic [cnb_pkg::ATTR_W-1:0]        s_attr_3,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_class_found,
    output logic [cnb_pkg::OUT_CLASS_W-1:0]   m_predicted_class
);

    localparam int DEPTH   = NUM_CLASSES * ATTR_VALUES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CW      = $clog2(NUM_CLASSES);
    localparam int CLSC_W  = $clog2(NUM_CLASSES + 1);
    localparam int AW      = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;
    localparam int LIMBS   = 2 * MAX_ATTRS - 1;
    localparam int LW      = (LIMBS > 1) ? $clog2(LIMBS) : 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [11:0] {
        ST_CLEAR   = 12'b0000_0000_0001,
        ST_IDLE    = 12'b0000_0000_0010,
        ST_TR_CLS  = 12'b0000_0000_0100,
        ST_TR_RD   = 12'b0000_0000_1000,
        ST_TR_WR   = 12'b0000_0001_0000,
        ST_P_CLASS = 12'b0000_0010_0000,
        ST_P_RD    = 12'b0000_0100_0000,
        ST_P_MUL   = 12'b0000_1000_0000,
        ST_P_MULN  = 12'b0001_0000_0000,
        ST_P_TERM  = 12'b0010_0000_0000,
        ST_P_CMP   = 12'b0100_0000_0000,
        ST_P_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [cnb_pkg::CFG_W-1:0]   attrs_reg;
    logic [COUNT_BITS-1:0]       cc_reg [NUM_CLASSES];
    logic [COUNT_BITS-1:0]       cc_next [NUM_CLASSES];

    logic                        action_reg, action_next;
    logic [cnb_pkg::LABEL_W-1:0] label_reg, label_next;
    logic [cnb_pkg::ATTR_W-1:0]  val_reg [cnb_pkg::ATTR_PORTS];
    logic [cnb_pkg::ATTR_W-1:0]  val_next [cnb_pkg::ATTR_PORTS];

    logic [ADDR_W-1:0]           clr_reg, clr_next;
    logic [CLSC_W-1:0]           cls_reg, cls_next;
    logic [CW-1:0]               tclass_reg, tclass_next;
    logic [CW-1:0]               best_reg, best_next;
    logic [COUNT_BITS-1:0]       nbest_reg, nbest_next;
    logic [COUNT_BITS-1:0]       ncur_reg, ncur_next;
    logic                        found_reg, found_next;
    logic                        phase_reg, phase_next;
    logic                        zero_reg, zero_next;
    logic                        vok_reg, vok_next;
    logic                        gt_reg, gt_next;
    logic [AW-1:0]               attr_reg, attr_next;
    logic [LW-1:0]               limb_reg, limb_next;
    logic [COUNT_BITS-1:0]       carry_reg, carry_next;
    logic [COUNT_BITS-1:0]       acc_reg [LIMBS];
    logic [COUNT_BITS-1:0]       acc_next [LIMBS];
    logic [COUNT_BITS-1:0]       lhs_reg [LIMBS];
    logic [COUNT_BITS-1:0]       lhs_next [LIMBS];

    logic                        m_valid_reg, m_valid_next;
    logic                        out_found_reg, out_found_next;
    logic [cnb_pkg::OUT_CLASS_W-1:0] out_class_reg, out_class_next;

    logic [cnb_pkg::CFG_W-1:0]   k_eff;
    logic [AW-1:0]               k_last;
    logic [CW-1:0]               label_cls;
    logic                        label_ok;
    logic [CW-1:0]               cc_idx;
    logic [COUNT_BITS-1:0]       cc_rd;
    logic [cnb_pkg::ATTR_W-1:0]  cur_val;
    logic                        cur_val_ok;

    logic                        ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]           ram_wr_addr, ram_rd_addr;
    logic [COUNT_BITS-1:0]       ram_wr_data, ram_rd_data;

    logic [COUNT_BITS-1:0]       mac_factor, mac_limb, mac_carry;

    cnb_count_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_BITS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    cnb_limb_mac #(
        .LIMB_W (COUNT_BITS)
    ) u_mac (
        .limb_in   (acc_reg[0]),
        .factor    (mac_factor),
        .carry_in  (carry_reg),
        .limb_out  (mac_limb),
        .carry_out (mac_carry)
    );

    always_comb begin
        if (attrs_reg == '0) begin
            k_eff = cnb_pkg::CFG_W'(1);
        end else if (attrs_reg > cnb_pkg::CFG_W'(MAX_ATTRS)) begin
            k_eff = cnb_pkg::CFG_W'(MAX_ATTRS);
        end else begin
            k_eff = attrs_reg;
        end
    end

    assign k_last     = AW'(k_eff - cnb_pkg::CFG_W'(1));
    assign label_ok   = (32'(label_reg) < NUM_CLASSES);
    assign label_cls  = CW'(label_reg);
    assign cc_idx     = (state_reg == ST_TR_CLS) ? label_cls : cls_reg[CW-1:0];
    assign cc_rd      = cc_reg[cc_idx];
    assign cur_val    = val_reg[2'(attr_reg)];
    assign cur_val_ok = (32'(cur_val) < ATTR_VALUES);

    assign mac_factor = (state_reg == ST_P_MULN) ? (phase_reg ? ncur_reg : nbest_reg)
                                                 : (vok_reg ? ram_rd_data : '0);

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_class_found     = out_found_reg;
    assign m_predicted_class = out_class_reg;

    always_comb begin
        state_next     = state_reg;
        cc_next        = cc_reg;
        action_next    = action_reg;
        label_next     = label_reg;
        val_next       = val_reg;
        clr_next       = clr_reg;
        cls_next       = cls_reg;
        tclass_next    = tclass_reg;
        best_next      = best_reg;
        nbest_next     = nbest_reg;
        ncur_next      = ncur_reg;
        found_next     = found_reg;
        phase_next     = phase_reg;
        zero_next      = zero_reg;
        vok_next       = vok_reg;
        gt_next        = gt_reg;
        attr_next      = attr_reg;
        limb_next      = limb_reg;
        carry_next     = carry_reg;
        acc_next       = acc_reg;
        lhs_next       = lhs_reg;
        out_found_next = out_found_reg;
        out_class_next = out_class_reg;
        m_valid_next   = m_valid_reg & ~m_ready;

        ram_wr_en   = 1'b0;
        ram_wr_addr = ADDR_W'(tclass_reg) * ADDR_W'(ATTR_VALUES) + ADDR_W'(cur_val);
        ram_wr_data = ram_rd_data + COUNT_BITS'(1);
        ram_rd_en   = 1'b0;
        ram_rd_addr = ram_wr_addr;

        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = '0;
                clr_next    = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    action_next = s_action;
                    label_next  = s_class_label;
                    val_next[0] = s_attr_0;
                    val_next[1] = s_attr_1;
                    val_next[2] = s_attr_2;
                    val_next[3] = s_attr_3;
                    attr_next   = '0;
                    cls_next    = '0;
                    found_next  = 1'b0;
                    best_next   = '0;
                    state_next  = (s_action == cnb_pkg::ACT_TRAIN) ? ST_TR_CLS : ST_P_CLASS;
                end
            end
            ST_TR_CLS: begin
                if (label_ok) begin
                    if (cc_rd != CNT_MAX) begin
                        cc_next[cc_idx] = cc_rd + COUNT_BITS'(1);
                    end
                    tclass_next = label_cls;
                    state_next  = ST_TR_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_TR_RD: begin
                ram_rd_en  = cur_val_ok;
                state_next = ST_TR_WR;
            end
            ST_TR_WR: begin
                ram_wr_en = cur_val_ok && (ram_rd_data != CNT_MAX);
                if (attr_reg == k_last) begin
                    state_next = ST_IDLE;
                end else begin
                    attr_next  = attr_reg + AW'(1);
                    state_next = ST_TR_RD;
                end
            end
            ST_P_CLASS: begin
                if (cls_reg == CLSC_W'(NUM_CLASSES)) begin
                    state_next = ST_P_DONE;
                end else if (cc_rd == '0) begin
                    cls_next = cls_reg + CLSC_W'(1);
                end else begin
                    ncur_next   = cc_rd;
                    tclass_next = cls_reg[CW-1:0];
                    phase_next  = 1'b0;
                    attr_next   = '0;
                    zero_next   = 1'b0;
                    for (int i = 0; i < LIMBS; i++) begin
                        acc_next[i] = (i == 0) ? COUNT_BITS'(1) : '0;
                    end
                    state_next = ST_P_RD;
                end
            end
            ST_P_RD: begin
                ram_rd_en  = cur_val_ok;
                vok_next   = cur_val_ok;
                limb_next  = '0;
                carry_next = '0;
                state_next = ST_P_MUL;
            end
            ST_P_MUL, ST_P_MULN: begin
                for (int i = 0; i < LIMBS - 1; i++) begin
                    acc_next[i] = acc_reg[i+1];
                end
                acc_next[LIMBS-1] = mac_limb;
                carry_next        = mac_carry;
                limb_next         = limb_reg + LW'(1);
                if (limb_reg == LW'(LIMBS - 1)) begin
                    limb_next  = '0;
                    carry_next = '0;
                    if (state_reg == ST_P_MUL) begin
                        zero_next = zero_reg | (mac_factor == '0);
                        if (attr_reg == k_last) begin
                            if (found_reg && (k_last != '0)) begin
                                attr_next  = AW'(1);
                                state_next = ST_P_MULN;
                            end else begin
                                state_next = ST_P_TERM;
                            end
                        end else begin
                            attr_next  = attr_reg + AW'(1);
                            state_next = ST_P_RD;
                        end
                    end else begin
                        if (attr_reg == k_last) begin
                            state_next = ST_P_TERM;
                        end else begin
                            attr_next = attr_reg + AW'(1);
                        end
                    end
                end
            end
            ST_P_TERM: begin
                if (!found_reg) begin
                    if (!zero_reg) begin
                        found_next = 1'b1;
                        best_next  = cls_reg[CW-1:0];
                        nbest_next = ncur_reg;
                    end
                    cls_next   = cls_reg + CLSC_W'(1);
                    state_next = ST_P_CLASS;
                end else if (!phase_reg) begin
                    lhs_next    = acc_reg;
                    phase_next  = 1'b1;
                    tclass_next = best_reg;
                    attr_next   = '0;
                    for (int i = 0; i < LIMBS; i++) begin
                        acc_next[i] = (i == 0) ? COUNT_BITS'(1) : '0;
                    end
                    state_next = ST_P_RD;
                end else begin
                    limb_next  = '0;
                    gt_next    = 1'b0;
                    state_next = ST_P_CMP;
                end
            end
            ST_P_CMP: begin
                // limbs compared from the bottom up; a higher differing limb overrides
                if (lhs_reg[0] != acc_reg[0]) begin
                    gt_next = (lhs_reg[0] > acc_reg[0]);
                end
                for (int i = 0; i < LIMBS - 1; i++) begin
                    acc_next[i] = acc_reg[i+1];
                    lhs_next[i] = lhs_reg[i+1];
                end
                acc_next[LIMBS-1] = acc_reg[0];
                lhs_next[LIMBS-1] = lhs_reg[0];
                limb_next         = limb_reg + LW'(1);
                if (limb_reg == LW'(LIMBS - 1)) begin
                    if (gt_next) begin
                        best_next  = cls_reg[CW-1:0];
                        nbest_next = ncur_reg;
                    end
                    cls_next   = cls_reg + CLSC_W'(1);
                    state_next = ST_P_CLASS;
                end
            end
            ST_P_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    out_found_next = found_reg;
                    out_class_next = found_reg ? cnb_pkg::OUT_CLASS_W'(best_reg) : '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            attrs_reg   <= cnb_pkg::ATTRS_RESET;
            clr_reg     <= '0;
            cls_reg     <= '0;
            found_reg   <= 1'b0;
            phase_reg   <= 1'b0;
            attr_reg    <= '0;
            limb_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                cc_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            if (cfg_we) begin
                attrs_reg <= cfg_wdata;
            end
            clr_reg     <= clr_next;
            cls_reg     <= cls_next;
            found_reg   <= found_next;
            phase_reg   <= phase_next;
            attr_reg    <= attr_next;
            limb_reg    <= limb_next;
            m_valid_reg <= m_valid_next;
            cc_reg      <= cc_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg    <= action_next;
        label_reg     <= label_next;
        val_reg       <= val_next;
        tclass_reg    <= tclass_next;
        best_reg      <= best_next;
        nbest_reg     <= nbest_next;
        ncur_reg      <= ncur_next;
        zero_reg      <= zero_next;
        vok_reg       <= vok_next;
        gt_reg        <= gt_next;
        carry_reg     <= carry_next;
        acc_reg       <= acc_next;
        lhs_reg       <= lhs_next;
        out_found_reg <= out_found_next;
        out_class_reg <= out_class_next;
    end

endmodule
